### design/fpr_pkg.sv
`timescale 1ns / 1ps

package fpr_pkg;

  // Field widths fixed by the interface
  localparam int DATA_W    = 32;
  localparam int RATE_W    = 56;
  localparam int MODE_W    = 2;
  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int SCALE_W   = 24;

  // 60000 ms per minute times 256 for the Q8 fraction
  localparam logic [SCALE_W-1:0] SCALE_Q8 = 24'd15360000;

  // Restoring divider: one quotient bit per step
  localparam int DIV_STEPS = RATE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Item actions
  localparam logic [ACT_W-1:0] ACT_EDGE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PRESET = 2'd2;

  // Edge modes
  localparam logic [MODE_W-1:0] MODE_IGNORE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UP     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOWN   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_TIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISING_MODE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALLING_MODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_EN     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } fpr_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic div_start;
    logic out_load;
  } fpr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic total_en;
    logic rate_valid;
    logic div_done;
    logic out_full;
  } fpr_sts_t;

endpackage

### design/fpr_in_if.sv
`timescale 1ns / 1ps

interface fpr_in_if import fpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [DATA_W-1:0] edge_time_us;
  logic              pin_level;
  logic [DATA_W-1:0] update_time_ms;
  logic [DATA_W-1:0] total_value;

  modport source (
    output valid, action, edge_time_us, pin_level, update_time_ms, total_value,
    input  ready
  );

  modport sink (
    input  valid, action, edge_time_us, pin_level, update_time_ms, total_value,
    output ready
  );
endinterface

### design/fpr_out_if.sv
`timescale 1ns / 1ps

interface fpr_out_if import fpr_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] delta_count;
  logic                     rate_valid;
  logic signed [RATE_W-1:0] rate_q8;
  logic [DATA_W-1:0]        total_count;
  logic                     total_valid;

  modport source (
    output valid, delta_count, rate_valid, rate_q8, total_count, total_valid,
    input  ready
  );

  modport sink (
    input  valid, delta_count, rate_valid, rate_q8, total_count, total_valid,
    output ready
  );
endinterface

### design/filtered_updown_pulse_rate_counter.sv
`timescale 1ns / 1ps
// Pin edges and presets without a result are taken one per cycle while the block is idle.
// An update with a rate passes the multiply state, the 56-step restoring divider and the
// done state, which holds while the output is full; the next item waits until idle.
// An update without a rate skips the divider; a reported preset goes straight to done.
// Synchronous active-low reset clears the counters, the times and the output valid and
// returns the registers to filter 0, rising up, falling ignore, total off.

module filtered_updown_pulse_rate_counter import fpr_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  fpr_in_if.sink               in_if,
  fpr_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  fpr_cmd_t cmd;
  fpr_sts_t sts;
  logic     in_ready;

  fpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_action (in_if.action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpr_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_action         (in_if.action),
    .in_edge_time_us   (in_if.edge_time_us),
    .in_pin_level      (in_if.pin_level),
    .in_update_time_ms (in_if.update_time_ms),
    .in_total_value    (in_if.total_value),
    .out_ready         (out_if.ready),
    .out_valid         (out_if.valid),
    .out_delta_count   (out_if.delta_count),
    .out_rate_valid    (out_if.rate_valid),
    .out_rate_q8       (out_if.rate_q8),
    .out_total_count   (out_if.total_count),
    .out_total_valid   (out_if.total_valid)
  );

  assign in_if.ready = in_ready;

endmodule

### design/fpr_div.sv
`timescale 1ns / 1ps

module fpr_div import fpr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RATE_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic [RATE_W-1:0] quotient,
  output logic              done
);

  logic                 busy_r,  busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r,   cnt_nxt;
  logic [RATE_W-1:0]    dvd_r,   dvd_nxt;
  logic [DATA_W-1:0]    rem_r,   rem_nxt;
  logic [DATA_W-1:0]    dsr_r,   dsr_nxt;
  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      diff;
  logic                 qbit;

  // Shift in the next dividend bit and try one subtract
  assign trial = {rem_r, dvd_r[RATE_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign qbit  = ~diff[DATA_W];

  assign done     = busy_r && (cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign quotient = dvd_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // Quotient bits replace dividend bits from the bottom
      dvd_nxt = {dvd_r[RATE_W-2:0], qbit};
      rem_nxt = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

### design/fpr_ctrl.sv
`timescale 1ns / 1ps

module fpr_ctrl import fpr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [ACT_W-1:0] in_action,
  output logic             in_ready,
  input  fpr_sts_t         sts,
  output fpr_cmd_t         cmd
);

  fpr_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = rst_n && (state_r == ST_IDLE);
    cmd.accept    = in_ready && in_valid;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_action)
            ACT_UPDATE: state_nxt = ST_MUL;
            ACT_PRESET: begin
              if (sts.total_en) begin
                state_nxt = ST_DONE;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MUL: begin
        if (sts.rate_valid) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
    endcase
  end

endmodule

### design/fpr_dp.sv
`timescale 1ns / 1ps

module fpr_dp import fpr_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fpr_cmd_t                 cmd,
  output fpr_sts_t                 sts,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic [ACT_W-1:0]         in_action,
  input  logic [DATA_W-1:0]        in_edge_time_us,
  input  logic                     in_pin_level,
  input  logic [DATA_W-1:0]        in_update_time_ms,
  input  logic [DATA_W-1:0]        in_total_value,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic signed [DATA_W-1:0] out_delta_count,
  output logic                     out_rate_valid,
  output logic signed [RATE_W-1:0] out_rate_q8,
  output logic [DATA_W-1:0]        out_total_count,
  output logic                     out_total_valid
);

  // Configuration
  logic [DATA_W-1:0] filter_time_r;
  logic [MODE_W-1:0] rising_mode_r;
  logic [MODE_W-1:0] falling_mode_r;
  logic              total_en_r;

  // Counter state
  logic [COUNT_WIDTH-1:0] pulse_count_r,  pulse_count_nxt;
  logic [COUNT_WIDTH-1:0] count_read_r,   count_read_nxt;
  logic [DATA_W-1:0]      last_edge_r,    last_edge_nxt;
  logic [DATA_W-1:0]      last_update_r,  last_update_nxt;
  logic                   had_update_r,   had_update_nxt;
  logic [DATA_W-1:0]      running_total_r, running_total_nxt;

  // Pending result
  logic [DATA_W-1:0] res_delta_r,  res_delta_nxt;
  logic [DATA_W-1:0] res_total_r,  res_total_nxt;
  logic              res_tvalid_r, res_tvalid_nxt;
  logic              rvalid_r,     rvalid_nxt;
  logic              neg_r,        neg_nxt;
  logic [DATA_W-1:0] mag_r,        mag_nxt;
  logic [DATA_W-1:0] interval_r,   interval_nxt;

  // Output register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_delta_r;
  logic              out_rvalid_r;
  logic [RATE_W-1:0] out_rate_r;
  logic [DATA_W-1:0] out_total_r;
  logic              out_tvalid_r;

  logic [DATA_W-1:0]      edge_gap;
  logic                   edge_drop;
  logic [MODE_W-1:0]      edge_mode;
  logic [COUNT_WIDTH-1:0] delta_cw;
  logic [DATA_W-1:0]      delta;
  logic [DATA_W-1:0]      interval;
  logic [DATA_W-1:0]      total_sum;
  logic [RATE_W-1:0]      rate_prod;
  logic [RATE_W-1:0]      quotient;
  logic [RATE_W-1:0]      rate_signed;
  logic                   div_done;

  // Edge filter and direction
  assign edge_gap  = in_edge_time_us - last_edge_r;
  assign edge_drop = edge_gap < filter_time_r;
  assign edge_mode = in_pin_level ? rising_mode_r : falling_mode_r;

  // Count change since the last update, widened with its sign
  assign delta_cw  = pulse_count_r - count_read_r;
  assign delta     = DATA_W'(signed'(delta_cw));
  assign interval  = in_update_time_ms - last_update_r;
  assign total_sum = running_total_r + delta;

  always_comb begin
    pulse_count_nxt   = pulse_count_r;
    count_read_nxt    = count_read_r;
    last_edge_nxt     = last_edge_r;
    last_update_nxt   = last_update_r;
    had_update_nxt    = had_update_r;
    running_total_nxt = running_total_r;
    res_delta_nxt     = res_delta_r;
    res_total_nxt     = res_total_r;
    res_tvalid_nxt    = res_tvalid_r;
    rvalid_nxt        = rvalid_r;
    neg_nxt           = neg_r;
    mag_nxt           = mag_r;
    interval_nxt      = interval_r;
    if (cmd.accept) begin
      unique case (in_action)
        ACT_EDGE: begin
          last_edge_nxt = in_edge_time_us;
          if (!edge_drop) begin
            if (edge_mode == MODE_UP) begin
              pulse_count_nxt = pulse_count_r + 1'b1;
            end else if (edge_mode == MODE_DOWN) begin
              pulse_count_nxt = pulse_count_r - 1'b1;
            end
          end
        end
        ACT_UPDATE: begin
          count_read_nxt  = pulse_count_r;
          last_update_nxt = in_update_time_ms;
          had_update_nxt  = 1'b1;
          res_delta_nxt   = delta;
          rvalid_nxt      = had_update_r && (interval != '0);
          neg_nxt         = delta[DATA_W-1];
          mag_nxt         = delta[DATA_W-1] ? (DATA_W'(0) - delta) : delta;
          interval_nxt    = interval;
          if (total_en_r) begin
            running_total_nxt = total_sum;
            res_total_nxt     = total_sum;
            res_tvalid_nxt    = 1'b1;
          end else begin
            res_total_nxt  = '0;
            res_tvalid_nxt = 1'b0;
          end
        end
        ACT_PRESET: begin
          running_total_nxt = in_total_value;
          res_delta_nxt     = '0;
          rvalid_nxt        = 1'b0;
          res_total_nxt     = in_total_value;
          res_tvalid_nxt    = 1'b1;
        end
        default: begin
          rvalid_nxt = rvalid_r;
        end
      endcase
    end
  end

  // Configuration and counter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_time_r   <= '0;
      rising_mode_r   <= MODE_UP;
      falling_mode_r  <= MODE_IGNORE;
      total_en_r      <= 1'b0;
      pulse_count_r   <= '0;
      count_read_r    <= '0;
      last_edge_r     <= '0;
      last_update_r   <= '0;
      had_update_r    <= 1'b0;
      running_total_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FILTER_TIME:  filter_time_r  <= cfg_wdata;
          REG_RISING_MODE:  rising_mode_r  <= cfg_wdata[MODE_W-1:0];
          REG_FALLING_MODE: falling_mode_r <= cfg_wdata[MODE_W-1:0];
          REG_TOTAL_EN:     total_en_r     <= cfg_wdata[0];
        endcase
      end
      pulse_count_r   <= pulse_count_nxt;
      count_read_r    <= count_read_nxt;
      last_edge_r     <= last_edge_nxt;
      last_update_r   <= last_update_nxt;
      had_update_r    <= had_update_nxt;
      running_total_r <= running_total_nxt;
    end
  end

  // Result payload for the item in flight
  always_ff @(posedge clk) begin
    res_delta_r  <= res_delta_nxt;
    res_total_r  <= res_total_nxt;
    res_tvalid_r <= res_tvalid_nxt;
    rvalid_r     <= rvalid_nxt;
    neg_r        <= neg_nxt;
    mag_r        <= mag_nxt;
    interval_r   <= interval_nxt;
  end

  // Scale the count magnitude; the divider registers the product
  assign rate_prod = RATE_W'(mag_r) * RATE_W'(SCALE_Q8);

  fpr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (rate_prod),
    .divisor  (interval_r),
    .quotient (quotient),
    .done     (div_done)
  );

  assign rate_signed = neg_r ? (RATE_W'(0) - quotient) : quotient;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_delta_r  <= res_delta_r;
      out_rvalid_r <= rvalid_r;
      out_rate_r   <= rvalid_r ? rate_signed : '0;
      out_total_r  <= res_total_r;
      out_tvalid_r <= res_tvalid_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_delta_count = signed'(out_delta_r);
  assign out_rate_valid  = out_rvalid_r;
  assign out_rate_q8     = signed'(out_rate_r);
  assign out_total_count = out_total_r;
  assign out_total_valid = out_tvalid_r;

  assign sts.total_en   = total_en_r;
  assign sts.rate_valid = rvalid_r;
  assign sts.div_done   = div_done;
  assign sts.out_full   = out_valid_r && !out_ready;

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending beat");

  // A result without a rate carries a zero rate
  a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rvalid_r) |-> (out_rate_r == '0))
    else $error("rate nonzero without rate_valid");

  // A preset loads the running total
  a_preset_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_action == ACT_PRESET) |=> (running_total_r == $past(in_total_value)))
    else $error("preset did not load the running total");

endmodule
